// ----- rtl/uart_line_editor_echo_unit_assert.svh -----
// Assertion macros for the line editor checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef UART_LINE_EDITOR_ECHO_UNIT_ASSERT_SVH
`define UART_LINE_EDITOR_ECHO_UNIT_ASSERT_SVH

// Same-cycle implication or plain property, sampled on the rising clock edge.
`define ULED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ULED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uled_pkg.sv -----
// Shared types, codes and the result decode for the line editor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uled_pkg;

  localparam int unsigned IDX_W = 6;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_NULL = 8'h00;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // What an accepted item will emit.
  typedef enum logic [2:0] {
    PLAN_QUIET     = 3'd0,
    PLAN_RUBOUT    = 3'd1,
    PLAN_ECHO      = 3'd2,
    PLAN_EOL       = 3'd3,
    PLAN_FULL_ECHO = 3'd4,
    PLAN_FULL_EOL  = 3'd5,
    PLAN_READ      = 3'd6
  } plan_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_ready;
    logic [7:0] read_data;
    logic       last;
  } out_item_t;

  // Result number 'step' of an item with the given plan.
  function automatic out_item_t result_of(plan_e plan, logic [1:0] step,
                                          logic [7:0] rx, logic [7:0] rd);
    out_item_t r;
    r = '0;
    case (plan)
      PLAN_RUBOUT: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = (step == 2'd1) ? CH_SP : CH_BS;
        r.last       = (step == 2'd2);
      end
      PLAN_ECHO: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = rx;
        r.last       = 1'b1;
      end
      PLAN_EOL: begin
        r.line_ready = 1'b1;
        r.last       = 1'b1;
      end
      PLAN_FULL_ECHO: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = (step == 2'd0) ? CH_BS : rx;
        r.last       = (step != 2'd0);
      end
      PLAN_FULL_EOL: begin
        r.echo_valid = (step == 2'd0);
        r.echo_byte  = (step == 2'd0) ? CH_BS : CH_NULL;
        r.line_ready = (step != 2'd0);
        r.last       = (step != 2'd0);
      end
      PLAN_READ: begin
        r.read_data = rd;
        r.last      = 1'b1;
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/uled_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Payload types come from uled_pkg at the instance.
`timescale 1ns / 1ps
`default_nettype none

interface uled_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/uart_line_editor_echo_unit.sv -----
// Console line editor with echo: line buffer, write pointer, result sequencer.
// Depends on uled_pkg and uled_stream_if.
//
//  channel | role    | payload     | transfer when
//  --------+---------+-------------+----------------------------
//  in_i    | sink    | in_item_t   | in_i.valid && in_i.ready
//  out_o   | source  | out_item_t  | out_o.valid && out_o.ready
//
//  Results: one each for echo, end of line, read, clear and no-op items;
//    two for a byte on a full line; three for a rubout.
//    The single output register takes one result per cycle from the
//    pending item while the output is not held.
//  Reset: pointer and control flags clear at once; buffer RAM is not swept.
//    The pointer doubles as fill count, so entries at or past it read zero.
//  Stalls: a held output keeps the pending item; input opens again in the
//    cycle its last result moves into the output register.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_editor_echo_unit
  import uled_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 64
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  uled_stream_if.sink   in_i,
  uled_stream_if.source out_o
);

  localparam int unsigned AW = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
  localparam int unsigned CW = (AW > IDX_W) ? AW : IDX_W;

  // Line buffer. Every entry below the write pointer was written since the
  // last clear; entries at or above it may hold stale bytes, masked on read.
  logic [7:0] line_mem [LINE_SIZE];

  logic [AW-1:0] wp_q, wp_d;

  // Pending item: plan, byte, read hit and the step of the next result.
  logic       job_v_q;
  plan_e      plan_q, plan_d;
  logic [7:0] byte_q;
  logic       hit_q, hit_d;
  logic [1:0] step_q;
  logic [7:0] rd_q;

  logic      out_v_q;
  out_item_t out_q;

  logic          in_fire;
  logic          job_adv;
  out_item_t     job_res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic          is_bs, is_eol, line_full;

  assign is_bs     = (in_i.data.rx_byte == CH_BS);
  assign is_eol    = (in_i.data.rx_byte == CH_CR) || (in_i.data.rx_byte == CH_LF);
  assign line_full = (wp_q == AW'(LINE_SIZE - 1));
  assign mem_raddr = AW'(in_i.data.read_index);
  assign hit_d     = (CW'(in_i.data.read_index) < CW'(wp_q));

  // Edit decode for the item at the input.
  always_comb begin
    wp_d      = wp_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    plan_d    = PLAN_QUIET;
    case (kind_e'(in_i.data.kind))
      KIND_RX: begin
        if (is_bs) begin
          // rubout only on a non-empty line
          if (wp_q != '0) begin
            plan_d = PLAN_RUBOUT;
            wp_d   = wp_q - AW'(1);
          end
        end else begin
          mem_we = 1'b1;
          if (line_full) begin
            // full line: overwrite the next-to-last entry, pointer stays
            mem_waddr = AW'(LINE_SIZE - 2);
            plan_d    = is_eol ? PLAN_FULL_EOL : PLAN_FULL_ECHO;
          end else begin
            wp_d   = wp_q + AW'(1);
            plan_d = is_eol ? PLAN_EOL : PLAN_ECHO;
          end
        end
      end
      KIND_READ: begin
        plan_d = PLAN_READ;
      end
      KIND_CLEAR: begin
        // the pointer is the fill count, so this empties the whole line
        wp_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Current result of the pending item; the read is masked past the fill.
  assign job_res = result_of(plan_q, step_q, byte_q, hit_q ? rd_q : CH_NULL);
  assign job_adv = job_v_q && (!out_v_q || out_o.ready);

  assign in_i.ready  = !job_v_q || (job_adv && job_res.last);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // Buffer RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      line_mem[mem_waddr] <= in_i.data.rx_byte;
    end
    if (in_fire) begin
      rd_q <= line_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      job_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire) begin
        wp_q <= wp_d;
      end
      if (in_fire) begin
        job_v_q <= 1'b1;
      end else if (job_adv && job_res.last) begin
        job_v_q <= 1'b0;
      end
      if (job_adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      plan_q <= plan_d;
      byte_q <= in_i.data.rx_byte;
      hit_q  <= hit_d;
      step_q <= 2'd0;
    end else if (job_adv && !job_res.last) begin
      step_q <= step_q + 2'd1;
    end
    if (job_adv) begin
      out_q <= job_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uled_checker.sv -----
// Port-level checks on the line editor output stream, bound to the top level.
// Depends on uled_pkg and uart_line_editor_echo_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "uart_line_editor_echo_unit_assert.svh"

module uled_checker
  import uled_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input out_item_t out_data_i
);

  // stalled result holds
  `ULED_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // end of line is always the closing result and carries nothing else
  `ULED_ASSERT(a_eol_last, out_valid_i && out_data_i.line_ready |-> out_data_i.last && !out_data_i.echo_valid && (out_data_i.read_data == CH_NULL), "line_ready on a non-final or mixed result")

  // read data only on the single result of a read
  `ULED_ASSERT(a_read_last, out_valid_i && (out_data_i.read_data != CH_NULL) |-> out_data_i.last && !out_data_i.echo_valid, "read_data on an echo result")

  // no stray echo byte without echo_valid
  `ULED_ASSERT(a_echo_zero, out_valid_i && !out_data_i.echo_valid |-> (out_data_i.echo_byte == CH_NULL), "echo_byte set without echo_valid")

endmodule

bind uart_line_editor_echo_unit uled_checker u_uled_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
